>>> rtl/core/lvh_pkg.sv
// Shared types and constants for the label volume histogram.
// Beat structs, controller states, and controller/datapath command and status.
// No dependencies.
`default_nettype none

package lvh_pkg;

    localparam int MAX_LABELS_DEF = 32;

    localparam int CNT_W     = 32;
    localparam int VOL_W     = 24;
    localparam int PROD_W    = 56;
    localparam int NLAB_W    = 6;
    localparam int LIDX_W    = 5;
    localparam int LABEL_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LABELS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_VOLUME = 2'd1;

    localparam logic [NLAB_W-1:0] NUM_LABELS_RST   = 6'd32;
    localparam logic [VOL_W-1:0]  VOXEL_VOLUME_RST = 24'd65536;

    typedef struct packed {
        logic               mode;
        logic [LABEL_W-1:0] label_value;
    } in_beat_t;

    typedef struct packed {
        logic [LIDX_W-1:0] label_index;
        logic [CNT_W-1:0]  voxel_count;
        logic [PROD_W-1:0] volume;
        logic              is_total;
        logic              last;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_FL_RD,
        ST_FL_ROW,
        ST_FL_TOT
    } state_t;

    typedef struct packed {
        logic latch_label;
        logic start_flush;
        logic rd_en;
        logic rd_sel_label;
        logic acc_write;
        logic load_row;
        logic load_total;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic in_range;
        logic last_idx;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/lvh_ctrl.sv
// Sequencer for the label volume histogram: accumulate and flush walks.
// Uses lvh_pkg state, command and status types.
`default_nettype none

module lvh_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire lvh_pkg::sts_t sts,
    output lvh_pkg::cmd_t     cmd
);

    lvh_pkg::state_t state_reg;
    lvh_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lvh_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lvh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.mode)
                    begin
                        cmd.start_flush = 1'b1;
                        state_next      = lvh_pkg::ST_FL_RD;
                    end
                    else if (sts.in_range)
                    begin
                        cmd.latch_label = 1'b1;
                        state_next      = lvh_pkg::ST_ACC_RD;
                    end
                end
            end
            lvh_pkg::ST_ACC_RD:
            begin
                cmd.rd_en        = 1'b1;
                cmd.rd_sel_label = 1'b1;
                state_next       = lvh_pkg::ST_ACC_WR;
            end
            lvh_pkg::ST_ACC_WR:
            begin
                cmd.acc_write = 1'b1;
                state_next    = lvh_pkg::ST_IDLE;
            end
            lvh_pkg::ST_FL_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = lvh_pkg::ST_FL_ROW;
            end
            lvh_pkg::ST_FL_ROW:
            begin
                if (sts.out_free)
                begin
                    cmd.load_row = 1'b1;
                    state_next   = sts.last_idx ? lvh_pkg::ST_FL_TOT : lvh_pkg::ST_FL_RD;
                end
            end
            lvh_pkg::ST_FL_TOT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_total = 1'b1;
                    state_next     = lvh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lvh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/lvh_datapath.sv
// Datapath: config registers, counter memory with per-entry valid bits,
// flush index and total, volume multiply and output register. Uses lvh_pkg.
`default_nettype none

module lvh_datapath #(
    parameter int MAX_LABELS = lvh_pkg::MAX_LABELS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [lvh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lvh_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  wire lvh_pkg::in_beat_t                   in_beat,
    output lvh_pkg::out_beat_t                       out_beat,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    input  wire lvh_pkg::cmd_t                       cmd,
    output lvh_pkg::sts_t                            sts
);

    localparam int IDX_W = $clog2(MAX_LABELS);

    logic [lvh_pkg::NLAB_W-1:0] num_labels_reg;
    logic [lvh_pkg::NLAB_W-1:0] num_labels_next;
    logic [lvh_pkg::VOL_W-1:0]  voxel_volume_reg;
    logic [lvh_pkg::VOL_W-1:0]  voxel_volume_next;

    logic [lvh_pkg::CNT_W-1:0]  counts_mem [MAX_LABELS];
    logic [MAX_LABELS-1:0]      valid_reg;
    logic [MAX_LABELS-1:0]      valid_next;
    logic [lvh_pkg::CNT_W-1:0]  rd_data_reg;
    logic                       rd_valid_reg;
    logic [IDX_W-1:0]           rd_addr;

    logic [IDX_W-1:0]           label_reg;
    logic [IDX_W-1:0]           label_next;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic [lvh_pkg::CNT_W-1:0]  sum_reg;
    logic [lvh_pkg::CNT_W-1:0]  sum_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    lvh_pkg::out_beat_t         out_beat_reg;
    lvh_pkg::out_beat_t         out_beat_next;

    logic [lvh_pkg::NLAB_W-1:0] n_act;
    logic [lvh_pkg::CNT_W-1:0]  cur_cnt;
    logic [lvh_pkg::CNT_W:0]    sum_wide;
    logic [lvh_pkg::CNT_W-1:0]  inc_cnt;
    logic [lvh_pkg::CNT_W-1:0]  mul_a;
    logic [lvh_pkg::PROD_W-1:0] product;
    logic [7:0]                 idx_ext;

    // active label count: zero acts as one, clamp to capacity
    always_comb
    begin
        if (num_labels_reg == '0)
        begin
            n_act = lvh_pkg::NLAB_W'(1);
        end
        else if (num_labels_reg > lvh_pkg::NLAB_W'(MAX_LABELS))
        begin
            n_act = lvh_pkg::NLAB_W'(MAX_LABELS);
        end
        else
        begin
            n_act = num_labels_reg;
        end
    end

    assign sts.mode     = in_beat.mode;
    assign sts.in_range = in_beat.label_value < lvh_pkg::LABEL_W'(n_act);
    assign sts.last_idx = lvh_pkg::NLAB_W'(idx_reg) == (n_act - lvh_pkg::NLAB_W'(1));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign rd_addr  = cmd.rd_sel_label ? label_reg : idx_reg;
    assign cur_cnt  = rd_valid_reg ? rd_data_reg : '0;
    assign inc_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + lvh_pkg::CNT_W'(1);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, cur_cnt};
    assign mul_a    = cmd.load_total ? sum_reg : cur_cnt;
    assign product  = lvh_pkg::PROD_W'(mul_a) * lvh_pkg::PROD_W'(voxel_volume_reg);
    assign idx_ext  = 8'(idx_reg);

    always_comb
    begin
        num_labels_next   = num_labels_reg;
        voxel_volume_next = voxel_volume_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lvh_pkg::CFG_NUM_LABELS:   num_labels_next   = cfg_data[lvh_pkg::NLAB_W-1:0];
                lvh_pkg::CFG_VOXEL_VOLUME: voxel_volume_next = cfg_data;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        label_next     = label_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        valid_next     = valid_reg;
        out_beat_next  = out_beat_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (cmd.latch_label)
        begin
            label_next = in_beat.label_value[IDX_W-1:0];
        end
        if (cmd.start_flush)
        begin
            idx_next = '0;
            sum_next = '0;
        end
        if (cmd.acc_write)
        begin
            valid_next[label_reg] = 1'b1;
        end
        if (cmd.load_row)
        begin
            out_valid_next            = 1'b1;
            out_beat_next.label_index = idx_ext[lvh_pkg::LIDX_W-1:0];
            out_beat_next.voxel_count = cur_cnt;
            out_beat_next.volume      = product;
            out_beat_next.is_total    = 1'b0;
            out_beat_next.last        = 1'b0;
            idx_next                  = idx_reg + IDX_W'(1);
            if (idx_reg != '0)
            begin
                sum_next = sum_wide[lvh_pkg::CNT_W] ? '1 : sum_wide[lvh_pkg::CNT_W-1:0];
            end
        end
        if (cmd.load_total)
        begin
            out_valid_next            = 1'b1;
            out_beat_next.label_index = '0;
            out_beat_next.voxel_count = sum_reg;
            out_beat_next.volume      = product;
            out_beat_next.is_total    = 1'b1;
            out_beat_next.last        = 1'b1;
            valid_next                = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_labels_reg   <= lvh_pkg::NUM_LABELS_RST;
            voxel_volume_reg <= lvh_pkg::VOXEL_VOLUME_RST;
            valid_reg        <= '0;
            out_valid_reg    <= 1'b0;
            idx_reg          <= '0;
            sum_reg          <= '0;
        end
        else
        begin
            num_labels_reg   <= num_labels_next;
            voxel_volume_reg <= voxel_volume_next;
            valid_reg        <= valid_next;
            out_valid_reg    <= out_valid_next;
            idx_reg          <= idx_next;
            sum_reg          <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg    <= label_next;
        out_beat_reg <= out_beat_next;
    end

    // counter memory: one read port, one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.acc_write)
        begin
            counts_mem[label_reg] <= inc_cnt;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg  <= counts_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

`default_nettype wire

>>> rtl/core/label_volume_histogram.sv
// Top level of the label volume histogram: controller plus datapath.
// Depends on lvh_pkg, lvh_ctrl and lvh_datapath.
//
// Counts voxels per label in a MAX_LABELS-deep counter memory and reports
// them on a flush beat. An accumulate beat is accepted, its counter read, and
// the saturating increment written back through the separate write port;
// labels at or above the active count are dropped. A flush beat is accepted,
// then each active label is read and sent as a row, then the total row, all
// stalling while out_ready is low; rows leave through an output register, so
// the last row may still wait while new beats are taken. Per-entry valid bits
// clear the memory at reset and after each flush, so there is no clearing pass.
`default_nettype none

module label_volume_histogram #(
    parameter int MAX_LABELS = lvh_pkg::MAX_LABELS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [lvh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lvh_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire lvh_pkg::in_beat_t             in_beat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output lvh_pkg::out_beat_t                 out_beat
);

    lvh_pkg::cmd_t cmd;
    lvh_pkg::sts_t sts;

    lvh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lvh_datapath #(
        .MAX_LABELS (MAX_LABELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_beat),
        .out_beat  (out_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
